[src/mmrc_pkg.sv]
// mmrc_pkg: shared types and constants for the meter reply checker
// request and response words, configuration struct, status and register codes
// no dependencies
package mmrc_pkg;

   // input word: one received byte
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   // result word: one checked frame
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] voltage_raw;
      logic [31:0] load_current;
      logic [31:0] real_power;
      logic [31:0] energy_count;
      logic [15:0] frequency_raw;
      logic [15:0] power_factor_raw;
      logic        alarm_active;
   } rsp_type;

   // configuration seen by the frame logic
   typedef struct packed {
      logic [7:0] device_address;
      logic       command_mode;
   } cfg_type;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXCEPTION = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd3;

   // register indexes
   localparam logic REG_DEVICE_ADDRESS = 1'b0;
   localparam logic REG_COMMAND_MODE   = 1'b1;

   // reset values of the registers
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;
   localparam logic       COMMAND_MODE_RESET   = 1'b0;

   // command modes
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_RESET = 1'b1;

   // frame format
   localparam logic [4:0]  READ_FRAME_LEN  = 5'd25;
   localparam logic [4:0]  RESET_FRAME_LEN = 5'd4;
   localparam logic [4:0]  DATA_FIRST_POS  = 5'd3;
   localparam logic [4:0]  DATA_END_POS    = 5'd23;
   localparam logic [4:0]  EXCEPTION_MIN   = 5'd5;
   localparam logic [7:0]  READ_FUNC       = 8'h04;
   localparam logic [7:0]  RESET_FUNC      = 8'h42;
   localparam logic [7:0]  EXCEPTION_BIT   = 8'h80;
   localparam logic [7:0]  READ_DATA_BYTES = 8'd20;
   localparam int          NUM_WORDS       = 10;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] ALARM_WORD      = 16'hFFFF;

endpackage

[src/modbus_meter_reply_checker.sv]
// modbus_meter_reply_checker: modbus rtu reply checker for an energy meter
// uses mmrc_csr and mmrc_frame; depends on mmrc_pkg
//
// Usage:
//   req channel carries one received byte per word with a frame_end flag on
//   the last byte of a reply. rsp channel returns one word per frame: the
//   status (ok, device exception, malformed, crc mismatch) and the unpacked
//   measurement fields, which read zero unless the status is ok in
//   read-measurements mode.
//   csr port: device_address at byte address 0, command_mode at 4.
//   Throughput: one byte per cycle while req_ready is high; the byte-wide crc
//   update and header capture finish in the accept cycle.
//   Result timing: the result of a frame is on rsp in the cycle after its
//   last byte is accepted.
//   Stall: the result register holds a word while rsp_ready is low, and
//   req_ready is low whenever a result is waiting and rsp_ready is low, so
//   no byte is taken until the waiting word leaves.
//   Reset: clears frame state and the result valid flag and restores the
//   registers to address 1 and read-measurements mode; no clearing pass.
module modbus_meter_reply_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mmrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mmrc_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import mmrc_pkg::*;

   cfg_type cfg;
   rsp_type result;
   logic    result_valid;
   logic    byte_accept;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   mmrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mmrc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .byte_accept  (byte_accept),
      .req_data     (req_data),
      .result_valid (result_valid),
      .result       (result)
   );

   // input side waits only while a result is stuck
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign byte_accept = req_valid && req_ready;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/mmrc_csr.sv]
// mmrc_csr: apb-style configuration registers for the meter reply checker
// holds device address and command mode; depends on mmrc_pkg
module mmrc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output mmrc_pkg::cfg_type cfg
);
   import mmrc_pkg::*;

   logic [7:0] device_address_ff, device_address_in;
   logic       command_mode_ff, command_mode_in;
   logic       write_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   // register write decode
   always_comb begin
      device_address_in = device_address_ff;
      command_mode_in   = command_mode_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_DEVICE_ADDRESS: device_address_in = csr_pwdata[7:0];
            REG_COMMAND_MODE:   command_mode_in   = csr_pwdata[0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         command_mode_ff   <= COMMAND_MODE_RESET;
      end else begin
         device_address_ff <= device_address_in;
         command_mode_ff   <= command_mode_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         REG_DEVICE_ADDRESS: csr_prdata = {24'd0, device_address_ff};
         REG_COMMAND_MODE:   csr_prdata = {31'd0, command_mode_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg.device_address = device_address_ff;
   assign cfg.command_mode   = command_mode_ff;

endmodule

[src/mmrc_frame.sv]
// mmrc_frame: per-byte frame tracking, crc-16 update and frame verdict
// keeps header, crc and data words; depends on mmrc_pkg
module mmrc_frame (
   input  logic              clock,
   input  logic              reset,
   input  mmrc_pkg::cfg_type cfg,
   input  logic              byte_accept,
   input  mmrc_pkg::req_type req_data,
   output logic              result_valid,
   output mmrc_pkg::rsp_type result
);
   import mmrc_pkg::*;

   // reflected crc-16 over one byte, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   logic [4:0]  byte_position_ff, byte_position_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic        address_matched_ff, address_matched_in;
   logic [7:0]  function_code_ff, function_code_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  pending_high_ff, pending_high_in;
   logic [15:0] words_ff [NUM_WORDS];
   logic [15:0] words_in [NUM_WORDS];

   logic [4:0]  limit;
   logic        in_range;
   logic        in_data;
   logic [4:0]  data_off;
   logic [3:0]  word_idx;
   logic [4:0]  pos_upd;
   logic [15:0] crc_upd;
   logic        addr_upd;
   logic [7:0]  func_upd;
   logic [7:0]  count_upd;
   logic [1:0]  status;
   logic        frame_end;

   assign limit     = (cfg.command_mode == MODE_RESET) ? RESET_FRAME_LEN : READ_FRAME_LEN;
   assign in_range  = byte_position_ff < limit;
   assign in_data   = (byte_position_ff >= DATA_FIRST_POS) && (byte_position_ff < DATA_END_POS);
   assign data_off  = byte_position_ff - DATA_FIRST_POS;
   assign word_idx  = data_off[4:1];
   assign frame_end = byte_accept && req_data.frame_end;

   // fold the byte into header, data words and crc
   always_comb begin
      pos_upd         = byte_position_ff;
      crc_upd         = running_crc_ff;
      addr_upd        = address_matched_ff;
      func_upd        = function_code_ff;
      count_upd       = byte_count_ff;
      pending_high_in = pending_high_ff;
      for (int k = 0; k < NUM_WORDS; k++) begin
         words_in[k] = words_ff[k];
      end
      if (byte_accept && in_range) begin
         if (byte_position_ff == 5'd0) begin
            addr_upd = (req_data.rx_byte == cfg.device_address);
         end else if (byte_position_ff == 5'd1) begin
            func_upd = req_data.rx_byte;
         end else if (byte_position_ff == 5'd2) begin
            count_upd = req_data.rx_byte;
         end
         if (in_data) begin
            if (!data_off[0]) begin
               pending_high_in = req_data.rx_byte;
            end else begin
               words_in[word_idx] = {pending_high_ff, req_data.rx_byte};
            end
         end
         crc_upd = crc_byte(running_crc_ff, req_data.rx_byte);
         pos_upd = byte_position_ff + 5'd1;
      end
   end

   // frame state returns to its start values after the last byte
   always_comb begin
      if (frame_end) begin
         byte_position_in   = 5'd0;
         running_crc_in     = CRC_INIT;
         address_matched_in = 1'b0;
         function_code_in   = 8'd0;
         byte_count_in      = 8'd0;
      end else begin
         byte_position_in   = pos_upd;
         running_crc_in     = crc_upd;
         address_matched_in = addr_upd;
         function_code_in   = func_upd;
         byte_count_in      = count_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= 5'd0;
         running_crc_ff     <= CRC_INIT;
         address_matched_ff <= 1'b0;
         function_code_ff   <= 8'd0;
         byte_count_ff      <= 8'd0;
      end else begin
         byte_position_ff   <= byte_position_in;
         running_crc_ff     <= running_crc_in;
         address_matched_ff <= address_matched_in;
         function_code_ff   <= function_code_in;
         byte_count_ff      <= byte_count_in;
      end
   end

   // data words and pending byte need no reset
   always_ff @(posedge clock) begin
      pending_high_ff <= pending_high_in;
      for (int k = 0; k < NUM_WORDS; k++) begin
         words_ff[k] <= words_in[k];
      end
   end

   // frame verdict, exception check first in read mode
   always_comb begin
      if (cfg.command_mode == MODE_READ) begin
         priority if (pos_upd >= EXCEPTION_MIN && addr_upd &&
                      func_upd == (READ_FUNC | EXCEPTION_BIT)) begin
            status = STATUS_EXCEPTION;
         end else if (pos_upd != limit || !addr_upd || func_upd != READ_FUNC ||
                      count_upd != READ_DATA_BYTES) begin
            status = STATUS_MALFORMED;
         end else if (crc_upd != 16'd0) begin
            status = STATUS_CRC_ERROR;
         end else begin
            status = STATUS_OK;
         end
      end else begin
         priority if (pos_upd != limit || !addr_upd || func_upd != RESET_FUNC) begin
            status = STATUS_MALFORMED;
         end else if (crc_upd != 16'd0) begin
            status = STATUS_CRC_ERROR;
         end else begin
            status = STATUS_OK;
         end
      end
   end

   // unpack measurements, zero unless a good read reply
   always_comb begin
      result        = '0;
      result.status = status;
      if (cfg.command_mode == MODE_READ && status == STATUS_OK) begin
         result.voltage_raw      = words_in[0];
         result.load_current     = {words_in[2], words_in[1]};
         result.real_power       = {words_in[4], words_in[3]};
         result.energy_count     = {words_in[6], words_in[5]};
         result.frequency_raw    = words_in[7];
         result.power_factor_raw = words_in[8];
         result.alarm_active     = (words_in[9] == ALARM_WORD);
      end
   end

   assign result_valid = frame_end;

endmodule

[src/mmrc_checker.sv]
// mmrc_checker: port-level assertions for the meter reply checker
// bound to modbus_meter_reply_checker; depends on mmrc_pkg
module mmrc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mmrc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mmrc_pkg::rsp_type rsp_data
);
   import mmrc_pkg::*;

   // a stalled result holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a last byte gives a result in the next cycle
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.frame_end |=> rsp_valid)
      else $error("no result after last byte");

   // a middle byte creates no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.frame_end && !(rsp_valid && !rsp_ready)
      |=> !rsp_valid)
      else $error("result without last byte");

   // measurement fields are zero on a failed frame
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
      rsp_data.voltage_raw == 16'd0 && rsp_data.load_current == 32'd0 &&
      rsp_data.real_power == 32'd0 && rsp_data.energy_count == 32'd0 &&
      rsp_data.frequency_raw == 16'd0 && rsp_data.power_factor_raw == 16'd0 &&
      !rsp_data.alarm_active)
      else $error("measurement fields set on failed frame");

endmodule

bind modbus_meter_reply_checker mmrc_checker u_mmrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: feeds modbus reply frames to the meter reply checker one byte per word
// and checks every result word against an in-bench prediction of the frame logic
// depends on mmrc_pkg and modbus_meter_reply_checker
module testbench;
   import mmrc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   // data patterns for a built read reply
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ONES   = 1;
   localparam int FILL_ZEROS  = 2;

   typedef enum int {
      KIND_GOOD, KIND_EXCEPTION, KIND_BAD_ADDRESS, KIND_BAD_FUNC, KIND_BAD_COUNT,
      KIND_BAD_CRC, KIND_SHORT, KIND_EXCESS, KIND_NOISE
   } reply_kind_type;

   // predicted frame state and the result words still due
   class reply_scoreboard;
      cfg_type     cfg;
      logic [4:0]  byte_pos;
      logic [15:0] crc;
      logic        addr_ok;
      logic [7:0]  func_code;
      logic [7:0]  count_field;
      logic [7:0]  high_byte;
      logic [15:0] words [NUM_WORDS];
      rsp_type     expected_replies[$];
      int          error_count;
      int          status_seen[4];

      function new();
         cfg.device_address = DEVICE_ADDRESS_RESET;
         cfg.command_mode   = COMMAND_MODE_RESET;
         clear_frame();
         high_byte   = '0;
         error_count = 0;
         foreach (words[i]) words[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      static function logic [15:0] fold_crc(logic [15:0] c, logic [7:0] b);
         c = c ^ {8'h00, b};
         repeat (8) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
         end
         return c;
      endfunction

      function void clear_frame();
         byte_pos    = '0;
         crc         = CRC_INIT;
         addr_ok     = 1'b0;
         func_code   = '0;
         count_field = '0;
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == REG_DEVICE_ADDRESS) cfg.device_address = value[7:0];
         else cfg.command_mode = value[0];
      endfunction

      // fold one accepted byte into the frame; a frame_end queues the result word
      function void note_byte(req_type w);
         logic [4:0] limit;
         int         off;
         rsp_type    r;
         limit = (cfg.command_mode == MODE_RESET) ? RESET_FRAME_LEN : READ_FRAME_LEN;
         // bytes past the frame length are dropped
         if (byte_pos < limit) begin
            if (byte_pos == 5'd0) addr_ok = (w.rx_byte == cfg.device_address);
            else if (byte_pos == 5'd1) func_code = w.rx_byte;
            else if (byte_pos == 5'd2) count_field = w.rx_byte;
            // data area: high byte first, then the word is stored
            if (byte_pos >= DATA_FIRST_POS && byte_pos < DATA_END_POS) begin
               off = int'(byte_pos - DATA_FIRST_POS);
               if (off % 2 == 0) high_byte = w.rx_byte;
               else words[off / 2] = {high_byte, w.rx_byte};
            end
            crc      = fold_crc(crc, w.rx_byte);
            byte_pos = byte_pos + 5'd1;
         end
         if (w.frame_end) begin
            r = '0;
            if (cfg.command_mode == MODE_READ) begin
               // device exception wins over every other check
               if (byte_pos >= EXCEPTION_MIN && addr_ok &&
                   func_code == (READ_FUNC | EXCEPTION_BIT))
                  r.status = STATUS_EXCEPTION;
               else if (byte_pos != limit || !addr_ok || func_code != READ_FUNC ||
                        count_field != READ_DATA_BYTES)
                  r.status = STATUS_MALFORMED;
               else if (crc != 16'h0000)
                  r.status = STATUS_CRC_ERROR;
               else
                  r.status = STATUS_OK;
               if (r.status == STATUS_OK) begin
                  r.voltage_raw      = words[0];
                  r.load_current     = {words[2], words[1]};
                  r.real_power       = {words[4], words[3]};
                  r.energy_count     = {words[6], words[5]};
                  r.frequency_raw    = words[7];
                  r.power_factor_raw = words[8];
                  r.alarm_active     = (words[9] == ALARM_WORD);
               end
            end else begin
               if (byte_pos != limit || !addr_ok || func_code != RESET_FUNC)
                  r.status = STATUS_MALFORMED;
               else if (crc != 16'h0000)
                  r.status = STATUS_CRC_ERROR;
               else
                  r.status = STATUS_OK;
            end
            expected_replies.push_back(r);
            clear_frame();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
         end
      endfunction

      // compare an accepted result word with the oldest prediction
      function void check_reply(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            $error("result word with none expected, status %0d", got.status);
            error_count++;
            return;
         end
         want = expected_replies.pop_front();
         status_seen[want.status]++;
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("voltage_raw", 32'(want.voltage_raw), 32'(got.voltage_raw));
         compare_field("load_current", want.load_current, got.load_current);
         compare_field("real_power", want.real_power, got.real_power);
         compare_field("energy_count", want.energy_count, got.energy_count);
         compare_field("frequency_raw", 32'(want.frequency_raw), 32'(got.frequency_raw));
         compare_field("power_factor_raw", 32'(want.power_factor_raw),
                       32'(got.power_factor_raw));
         compare_field("alarm_active", 32'(want.alarm_active), 32'(got.alarm_active));
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit              idle_on     = 1'b1;
   int              stall_left  = 0;
   int              idle_cycles = 0;
   int              bytes_sent  = 0;
   logic [7:0]      frame_buf[$];
   reply_scoreboard board = new;

   modbus_meter_reply_checker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // result side stalls in random bursts while idling is on
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watch both channels at the edge where words move
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_reply(rsp_data);
         if (req_valid && req_ready) board.note_byte(req_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on a stuck channel
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // append the trailer, low byte first, so the crc over the frame ends at zero
   function automatic void add_crc();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_buf[i]) c = reply_scoreboard::fold_crc(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endfunction

   // header and data of a reply for the given mode, without trailer
   function automatic void build_reply(logic mode, int fill);
      frame_buf.delete();
      frame_buf.push_back(board.cfg.device_address);
      if (mode == MODE_RESET) begin
         frame_buf.push_back(RESET_FUNC);
      end else begin
         frame_buf.push_back(READ_FUNC);
         frame_buf.push_back(READ_DATA_BYTES);
         repeat (READ_DATA_BYTES) begin
            if (fill == FILL_ONES) frame_buf.push_back(8'hFF);
            else if (fill == FILL_ZEROS) frame_buf.push_back(8'h00);
            else frame_buf.push_back(8'($urandom));
         end
         // now and then the alarm word reads all ones
         if (fill == FILL_RANDOM && $urandom_range(0, 2) == 0) begin
            frame_buf[frame_buf.size() - 1] = 8'hFF;
            frame_buf[frame_buf.size() - 2] = 8'hFF;
         end
      end
   endfunction

   function automatic void build_exception();
      frame_buf.delete();
      frame_buf.push_back(board.cfg.device_address);
      frame_buf.push_back(READ_FUNC | EXCEPTION_BIT);
      frame_buf.push_back(8'($urandom_range(1, 11)));
   endfunction

   // one byte word, with an optional gap before it
   task automatic send_byte(input logic [7:0] b, input bit last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: b, frame_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_bytes(input int first_idx, input int end_idx, input bit mark_end);
      for (int i = first_idx; i < end_idx; i++)
         send_byte(frame_buf[i], mark_end && (i == end_idx - 1));
   endtask

   // hold the sender until every predicted word has come back
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // apb write: setup cycle, access cycle, then idle
   task automatic write_register(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed replies with random data, the rest broken or noise
   task automatic send_random_reply();
      int             roll;
      int             n;
      int             idx;
      reply_kind_type kind;
      logic [7:0]     addr;
      addr = board.cfg.device_address;
      roll = $urandom_range(0, 99);
      if (roll < 52) kind = KIND_GOOD;
      else if (roll < 60) kind = KIND_EXCEPTION;
      else if (roll < 66) kind = KIND_BAD_ADDRESS;
      else if (roll < 72) kind = KIND_BAD_FUNC;
      else if (roll < 77) kind = KIND_BAD_COUNT;
      else if (roll < 84) kind = KIND_BAD_CRC;
      else if (roll < 90) kind = KIND_SHORT;
      else if (roll < 95) kind = KIND_EXCESS;
      else kind = KIND_NOISE;
      build_reply(board.cfg.command_mode,
                  (roll < 4) ? FILL_ONES : ((roll < 7) ? FILL_ZEROS : FILL_RANDOM));
      // header faults, trailer still correct
      case (kind)
         KIND_EXCEPTION: build_exception();
         KIND_BAD_ADDRESS: begin
            do frame_buf[0] = 8'($urandom); while (frame_buf[0] == addr);
         end
         KIND_BAD_FUNC: begin
            idx = $urandom_range(0, 3);
            frame_buf[1] = (idx == 0) ? READ_FUNC :
                           (idx == 1) ? RESET_FUNC :
                           (idx == 2) ? (RESET_FUNC | EXCEPTION_BIT) : 8'($urandom);
         end
         KIND_BAD_COUNT: begin
            if (frame_buf.size() > 2)
               frame_buf[2] = frame_buf[2] ^ 8'(1 << $urandom_range(0, 7));
            else
               frame_buf[1] = 8'($urandom);
         end
         default: ;
      endcase
      add_crc();
      // faults in the byte stream itself
      case (kind)
         KIND_BAD_CRC: begin
            idx = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
         end
         KIND_SHORT: begin
            n = $urandom_range(1, frame_buf.size() - 1);
            while (frame_buf.size() > n) void'(frame_buf.pop_back());
         end
         KIND_EXCESS: begin
            repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
         end
         KIND_NOISE: begin
            frame_buf.delete();
            repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
         end
         default: ;
      endcase
      // a missing frame_end now and then runs two frames together
      send_bytes(0, frame_buf.size(), $urandom_range(0, 24) != 0);
   endtask

   task automatic send_random_bytes(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_reply();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on settings: full-scale data with alarm set
      build_reply(MODE_READ, FILL_ONES);
      add_crc();
      send_bytes(0, frame_buf.size(), 1'b1);
      // all-zero data followed by bytes past the frame length
      build_reply(MODE_READ, FILL_ZEROS);
      add_crc();
      repeat (3) frame_buf.push_back(8'($urandom));
      send_bytes(0, frame_buf.size(), 1'b1);
      // device exception, then the same cut below the minimum length
      build_exception();
      add_crc();
      send_bytes(0, frame_buf.size(), 1'b1);
      void'(frame_buf.pop_back());
      send_bytes(0, frame_buf.size(), 1'b1);
      // lone byte with frame_end
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      send_bytes(0, 1, 1'b1);

      // highest address, read mode
      drain_replies();
      write_register(REG_DEVICE_ADDRESS, 32'd248);
      write_register(REG_COMMAND_MODE, 32'(MODE_READ));
      send_random_bytes(350);

      // reset-energy echoes: good one, then one with the read function code
      drain_replies();
      write_register(REG_COMMAND_MODE, 32'(MODE_RESET));
      build_reply(MODE_RESET, FILL_RANDOM);
      add_crc();
      send_bytes(0, frame_buf.size(), 1'b1);
      build_reply(MODE_RESET, FILL_RANDOM);
      frame_buf[1] = READ_FUNC;
      add_crc();
      send_bytes(0, frame_buf.size(), 1'b1);
      send_random_bytes(250);

      // header sent in reset mode, rest of the read reply after the mode change
      build_reply(MODE_READ, FILL_RANDOM);
      add_crc();
      send_bytes(0, 3, 1'b0);
      drain_replies();
      write_register(REG_COMMAND_MODE, 32'(MODE_READ));
      send_bytes(3, frame_buf.size(), 1'b1);

      // mid-range address, read mode
      drain_replies();
      write_register(REG_DEVICE_ADDRESS, 32'($urandom_range(2, 247)));
      send_random_bytes(300);

      // echo begun in read mode and finished after switching to reset mode
      build_reply(MODE_RESET, FILL_RANDOM);
      add_crc();
      send_bytes(0, 2, 1'b0);
      drain_replies();
      write_register(REG_COMMAND_MODE, 32'(MODE_RESET));
      send_bytes(2, frame_buf.size(), 1'b1);
      send_random_bytes(200);

      // lowest address, read mode, no idling on either side
      drain_replies();
      write_register(REG_DEVICE_ADDRESS, 32'd1);
      write_register(REG_COMMAND_MODE, 32'(MODE_READ));
      idle_on = 1'b0;
      send_random_bytes(250);

      drain_replies();
      $display("covered %0d bytes: good, exception, broken, short, long and noise frames,",
               bytes_sent);
      $display("both modes, mid-frame mode changes; %0d ok, %0d exception, %0d malformed, %0d crc",
               board.status_seen[STATUS_OK], board.status_seen[STATUS_EXCEPTION],
               board.status_seen[STATUS_MALFORMED], board.status_seen[STATUS_CRC_ERROR]);
      if (board.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
